// ===== rtl/core/dmr_pkg.sv =====
// ----------------------------------------------------------------------------
// dmr_pkg
// Shared types, constants and helpers for the dual motor ramp block.
// ----------------------------------------------------------------------------
package dmr_pkg;

  // field widths
  localparam int unsigned CmdW   = 16;
  localparam int unsigned SpeedW = 9;
  localparam int unsigned CfgW   = 8;
  localparam int unsigned CfgIdxW = 3;
  // wide enough for target minus current of two 9-bit speeds
  localparam int unsigned CalcW  = 11;

  // register reset values
  localparam logic [CfgW-1:0] ThrLimitRst = 8'd200;
  localparam logic [CfgW-1:0] ThrStepRst  = 8'd5;
  localparam logic [CfgW-1:0] ThrKickRst  = 8'd128;
  localparam logic [CfgW-1:0] StrLimitRst = 8'd250;
  localparam logic [CfgW-1:0] StrStepRst  = 8'd20;
  localparam logic [CfgW-1:0] StrKickRst  = 8'd150;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_THR_LIMIT = 3'd0,
    REG_THR_STEP  = 3'd1,
    REG_THR_KICK  = 3'd2,
    REG_STR_LIMIT = 3'd3,
    REG_STR_STEP  = 3'd4,
    REG_STR_KICK  = 3'd5
  } cfg_idx_e;

  // item opcodes
  typedef enum logic {
    OP_SET  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // per-channel settings
  typedef struct packed {
    logic [CfgW-1:0] limit;
    logic [CfgW-1:0] step;
    logic [CfgW-1:0] kick;
  } ch_cfg_t;

  // magnitude of a ramp value, never overflows for speeds within +/-255
  function automatic logic signed [CalcW-1:0] mag(input logic signed [CalcW-1:0] v);
    mag = (v < 0) ? -v : v;
  endfunction

endpackage

// ===== rtl/core/dmr_in_if.sv =====
// ----------------------------------------------------------------------------
// dmr_in_if
// Input item channel: opcode and the two signed commands.
// ----------------------------------------------------------------------------
interface dmr_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [15:0] throttle_command;
  logic signed [15:0] steer_command;

  modport source (
    output valid, opcode, throttle_command, steer_command,
    input  ready
  );
  modport sink (
    input  valid, opcode, throttle_command, steer_command,
    output ready
  );
endinterface

// ===== rtl/core/dmr_out_if.sv =====
// ----------------------------------------------------------------------------
// dmr_out_if
// Result item channel: both speeds and the four bridge duty values.
// ----------------------------------------------------------------------------
interface dmr_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] throttle_speed;
  logic signed [8:0] steer_speed;
  logic [7:0]        throttle_fwd_duty;
  logic [7:0]        throttle_rev_duty;
  logic [7:0]        steer_left_duty;
  logic [7:0]        steer_right_duty;

  modport source (
    output valid, throttle_speed, steer_speed, throttle_fwd_duty,
           throttle_rev_duty, steer_left_duty, steer_right_duty,
    input  ready
  );
  modport sink (
    input  valid, throttle_speed, steer_speed, throttle_fwd_duty,
           throttle_rev_duty, steer_left_duty, steer_right_duty,
    output ready
  );
endinterface

// ===== rtl/core/dmr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dmr_cfg_regs
// Limit, step and kick registers for both channels, plain write port.
// ----------------------------------------------------------------------------
module dmr_cfg_regs import dmr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output ch_cfg_t            thr_cfg_o,
  output ch_cfg_t            str_cfg_o
);

  ch_cfg_t thr_q, thr_d;
  ch_cfg_t str_q, str_d;

  // decode the write, unknown indexes are dropped
  always_comb begin
    thr_d = thr_q;
    str_d = str_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_THR_LIMIT: thr_d.limit = cfg_data_i;
        REG_THR_STEP:  thr_d.step  = cfg_data_i;
        REG_THR_KICK:  thr_d.kick  = cfg_data_i;
        REG_STR_LIMIT: str_d.limit = cfg_data_i;
        REG_STR_STEP:  str_d.step  = cfg_data_i;
        REG_STR_KICK:  str_d.kick  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '{limit: ThrLimitRst, step: ThrStepRst, kick: ThrKickRst};
      str_q <= '{limit: StrLimitRst, step: StrStepRst, kick: StrKickRst};
    end else begin
      thr_q <= thr_d;
      str_q <= str_d;
    end
  end

  assign thr_cfg_o = thr_q;
  assign str_cfg_o = str_q;

endmodule

// ===== rtl/core/dmr_channel.sv =====
// ----------------------------------------------------------------------------
// dmr_channel
// One motor channel: target and speed registers, clamp and ramp step.
// ----------------------------------------------------------------------------
module dmr_channel import dmr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  logic                     opcode_i,
  input  logic signed [CmdW-1:0]   command_i,
  input  ch_cfg_t                  cfg_i,
  output logic signed [SpeedW-1:0] speed_o
);

  logic signed [SpeedW-1:0] target_q, target_d;
  logic signed [SpeedW-1:0] current_q, current_d;

  logic signed [CmdW:0]     cmd_x;
  logic signed [CmdW:0]     lim_x;
  logic signed [SpeedW-1:0] clamped;

  logic signed [CalcW-1:0]  tgt;
  logic signed [CalcW-1:0]  kick;
  logic signed [CalcW-1:0]  step;
  logic signed [CalcW-1:0]  cur_kick;
  logic signed [CalcW-1:0]  cur_cut;
  logic signed [CalcW-1:0]  diff;
  logic signed [CalcW-1:0]  cur_ramp;

  // symmetric clamp of the command to the limit
  always_comb begin
    cmd_x = {command_i[CmdW-1], command_i};
    lim_x = signed'({{(CmdW+1-CfgW){1'b0}}, cfg_i.limit});
    if (cmd_x > lim_x) begin
      clamped = lim_x[SpeedW-1:0];
    end else if (cmd_x < -lim_x) begin
      clamped = SpeedW'(-lim_x);
    end else begin
      clamped = cmd_x[SpeedW-1:0];
    end
  end

  // one ramp step: kick from rest, cut to target, then slew
  always_comb begin
    tgt  = CalcW'(target_q);
    kick = signed'({{(CalcW-CfgW){1'b0}}, cfg_i.kick});
    step = signed'({{(CalcW-CfgW){1'b0}}, cfg_i.step});

    if (current_q == '0) begin
      cur_kick = (tgt > 0) ? kick : -kick;
    end else begin
      cur_kick = CalcW'(current_q);
    end

    cur_cut = (mag(cur_kick) > mag(tgt)) ? tgt : cur_kick;
    diff    = tgt - cur_cut;

    if (tgt == '0) begin
      cur_ramp = '0;
    end else if (mag(diff) > step) begin
      cur_ramp = (diff > 0) ? cur_cut + step : cur_cut - step;
    end else begin
      cur_ramp = tgt;
    end
  end

  // state update for an item entering the result stage
  always_comb begin
    target_d  = target_q;
    current_d = current_q;
    if (load_i) begin
      case (op_e'(opcode_i))
        OP_SET:  target_d  = clamped;
        OP_TICK: current_d = cur_ramp[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      current_q <= '0;
    end else begin
      target_q  <= target_d;
      current_q <= current_d;
    end
  end

  assign speed_o = current_d;

endmodule

// ===== rtl/core/dual_motor_ramp_with_kick_start.sv =====
// ----------------------------------------------------------------------------
// dual_motor_ramp_with_kick_start
// Throttle and steering slew-rate limiter with kick start and bridge duties.
// ----------------------------------------------------------------------------
// Usage:
// - in_i carries one item per handshake: opcode 0 loads new clamped targets,
//   opcode 1 advances both channels one ramp step
// - out_i returns exactly one result item per input item: both speeds and the
//   four H-bridge duty values after that item
// - configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i);
//   write it only while no item is in flight, unknown indexes are ignored
// - after the input handshake the item waits in the input register, then
//   goes through the clamp/ramp logic into the result register, where
//   result valid rises and the item can be taken
// - one item per cycle unless the receiver stalls; the clamp and ramp are
//   a few narrow adders and compares between the input and result registers
// - when the receiver stalls, the result register holds and the input
//   register fills; in_i.ready drops only when both stages are full
// - reset empties both stages, zeroes targets and speeds and loads the
//   default limits, steps and kicks
// ----------------------------------------------------------------------------
module dual_motor_ramp_with_kick_start import dmr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  dmr_in_if.sink             in_i,
  dmr_out_if.source          out_i
);

  ch_cfg_t thr_cfg;
  ch_cfg_t str_cfg;

  // input register
  logic                   s1_valid_q;
  logic                   s1_op_q;
  logic signed [CmdW-1:0] s1_thr_q;
  logic signed [CmdW-1:0] s1_str_q;

  // result register
  logic                     out_valid_q;
  logic signed [SpeedW-1:0] thr_speed_q, str_speed_q;
  logic [CfgW-1:0]          thr_fwd_q, thr_rev_q, str_left_q, str_right_q;

  logic                     out_free;
  logic                     s1_adv;
  logic                     in_acc;
  logic signed [SpeedW-1:0] thr_speed_d, str_speed_d;
  logic [CfgW-1:0]          thr_fwd_d, thr_rev_d, str_left_d, str_right_d;
  logic signed [SpeedW-1:0] thr_neg, str_neg;

  // handshake flow
  assign out_free   = !out_valid_q || out_i.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_acc     = in_i.valid && in_i.ready;

  dmr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .thr_cfg_o  (thr_cfg),
    .str_cfg_o  (str_cfg)
  );

  dmr_channel u_thr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (s1_adv),
    .opcode_i  (s1_op_q),
    .command_i (s1_thr_q),
    .cfg_i     (thr_cfg),
    .speed_o   (thr_speed_d)
  );

  dmr_channel u_str (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (s1_adv),
    .opcode_i  (s1_op_q),
    .command_i (s1_str_q),
    .cfg_i     (str_cfg),
    .speed_o   (str_speed_d)
  );

  // bridge duties from the new speeds
  always_comb begin
    thr_neg     = -thr_speed_d;
    str_neg     = -str_speed_d;
    thr_fwd_d   = (thr_speed_d > 0) ? thr_speed_d[CfgW-1:0] : '0;
    thr_rev_d   = (thr_speed_d < 0) ? thr_neg[CfgW-1:0] : '0;
    str_left_d  = (str_speed_d < 0) ? str_neg[CfgW-1:0] : '0;
    str_right_d = (str_speed_d > 0) ? str_speed_d[CfgW-1:0] : '0;
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // input payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q  <= in_i.opcode;
      s1_thr_q <= in_i.throttle_command;
      s1_str_q <= in_i.steer_command;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      thr_speed_q <= thr_speed_d;
      str_speed_q <= str_speed_d;
      thr_fwd_q   <= thr_fwd_d;
      thr_rev_q   <= thr_rev_d;
      str_left_q  <= str_left_d;
      str_right_q <= str_right_d;
    end
  end

  assign out_i.valid             = out_valid_q;
  assign out_i.throttle_speed    = thr_speed_q;
  assign out_i.steer_speed       = str_speed_q;
  assign out_i.throttle_fwd_duty = thr_fwd_q;
  assign out_i.throttle_rev_duty = thr_rev_q;
  assign out_i.steer_left_duty   = str_left_q;
  assign out_i.steer_right_duty  = str_right_q;

endmodule
